// File: sv/gwch_pkg.sv
`timescale 1ns / 1ps

package gwch_pkg;

    localparam int HULL_IDX_BITS = 5;
    localparam int UPC_W         = 4;

    typedef logic [UPC_W-1:0] upc_t;

    // Datapath operations selected by the control word.
    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_RINIT,
        OP_LDB,
        OP_LDC,
        OP_MUL1,
        OP_MUL2,
        OP_CMP,
        OP_INC_I,
        OP_ADVANCE,
        OP_EMIT
    } op_t;

    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_I_END,
        C_I_PIVOT,
        C_CLOSED,
        C_NOT_LIMIT,
        C_MORE
    } cond_t;

    typedef enum logic [1:0] {
        W_NONE,
        W_START,
        W_OUT
    } wait_t;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        wait_t wt;
        upc_t  target;
    } ctrl_t;

    // Step addresses of the control program.
    localparam upc_t UA_RINIT = 4'd0;
    localparam upc_t UA_LDB   = 4'd1;
    localparam upc_t UA_TEST  = 4'd2;
    localparam upc_t UA_SKIP  = 4'd3;
    localparam upc_t UA_LDC   = 4'd4;
    localparam upc_t UA_MUL1  = 4'd5;
    localparam upc_t UA_MUL2  = 4'd6;
    localparam upc_t UA_CMP   = 4'd7;
    localparam upc_t UA_NEXTI = 4'd8;
    localparam upc_t UA_CLOSE = 4'd9;
    localparam upc_t UA_ADV   = 4'd10;
    localparam upc_t UA_DRD   = 4'd11;
    localparam upc_t UA_DOUT  = 4'd12;
    localparam upc_t UA_IDLE  = 4'd13;

    // Control store. A step waits until its wait condition holds, then jumps to
    // the target when its condition is true and falls through otherwise.
    function automatic ctrl_t gwch_ucode(input upc_t upc);
        ctrl_t w;
        unique case (upc)
            UA_RINIT: w = '{op: OP_RINIT,   cond: C_NEVER,     wt: W_NONE,  target: UA_RINIT};
            UA_LDB:   w = '{op: OP_LDB,     cond: C_NEVER,     wt: W_NONE,  target: UA_RINIT};
            UA_TEST:  w = '{op: OP_NOP,     cond: C_I_END,     wt: W_NONE,  target: UA_CLOSE};
            UA_SKIP:  w = '{op: OP_NOP,     cond: C_I_PIVOT,   wt: W_NONE,  target: UA_NEXTI};
            UA_LDC:   w = '{op: OP_LDC,     cond: C_NEVER,     wt: W_NONE,  target: UA_RINIT};
            UA_MUL1:  w = '{op: OP_MUL1,    cond: C_NEVER,     wt: W_NONE,  target: UA_RINIT};
            UA_MUL2:  w = '{op: OP_MUL2,    cond: C_NEVER,     wt: W_NONE,  target: UA_RINIT};
            UA_CMP:   w = '{op: OP_CMP,     cond: C_NEVER,     wt: W_NONE,  target: UA_RINIT};
            UA_NEXTI: w = '{op: OP_INC_I,   cond: C_ALWAYS,    wt: W_NONE,  target: UA_TEST};
            UA_CLOSE: w = '{op: OP_NOP,     cond: C_CLOSED,    wt: W_NONE,  target: UA_DRD};
            UA_ADV:   w = '{op: OP_ADVANCE, cond: C_NOT_LIMIT, wt: W_NONE,  target: UA_RINIT};
            UA_DRD:   w = '{op: OP_NOP,     cond: C_NEVER,     wt: W_NONE,  target: UA_RINIT};
            UA_DOUT:  w = '{op: OP_EMIT,    cond: C_MORE,      wt: W_OUT,   target: UA_DRD};
            default:  w = '{op: OP_LOAD,    cond: C_ALWAYS,    wt: W_START, target: UA_RINIT};
        endcase
        return w;
    endfunction

endpackage

// File: sv/gift_wrapping_convex_hull.sv
`timescale 1ns / 1ps

// Loading: one point per cycle; in_ready is high only while idle, not during a hull run or its result output.
// Hull run: the length of a round for n stored points is set by the
// shared multiplier (two products per point) and the single read port of the point memory.
// Up to n + 2 rounds; results follow the whole run, and a beat waits while the last one is not taken.
// Reset (rst_n low, asynchronous) empties the point set and clears out_valid; the
// block is ready for points in the first cycle after reset.
module gift_wrapping_convex_hull #(
    parameter int MAX_POINTS = 32,
    parameter int COORD_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [COORD_BITS-1:0]        x_coord,
    input  logic signed [COORD_BITS-1:0]        y_coord,
    input  logic                                last_point,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [gwch_pkg::HULL_IDX_BITS-1:0]  hull_index,
    output logic                                last_vertex,
    output logic                                unfinished
);

    import gwch_pkg::*;

    localparam int IDX_W    = $clog2(MAX_POINTS);
    localparam int CNT_W    = $clog2(MAX_POINTS + 1);
    localparam int HB_DEPTH = MAX_POINTS + 2;
    localparam int HB_AW    = $clog2(HB_DEPTH);
    localparam int HB_CW    = $clog2(HB_DEPTH + 1);
    localparam int PW       = COORD_BITS + 1;
    localparam int DW       = COORD_BITS + 2;
    localparam int PRW      = 2 * DW;

    // Point and hull memories.
    logic [2*COORD_BITS-1:0] pt_mem [MAX_POINTS];
    logic [2*COORD_BITS-1:0] pt_rdata_reg;
    logic [IDX_W-1:0]        pt_waddr;
    logic [IDX_W-1:0]        pt_raddr;
    logic                    pt_we;
    logic [IDX_W-1:0]        hb_mem [HB_DEPTH];
    logic [IDX_W-1:0]        hb_rdata_reg;
    logic                    hb_we;

    // Sequencer and datapath registers.
    upc_t                         upc_reg, upc_next;
    logic [CNT_W-1:0]             count_reg, count_next;
    logic [CNT_W-1:0]             n_reg, n_next;
    logic signed [COORD_BITS-1:0] min_x_reg, min_x_next;
    logic signed [COORD_BITS-1:0] min_y_reg, min_y_next;
    logic signed [PW-1:0]         px_reg, px_next;
    logic signed [PW-1:0]         py_reg, py_next;
    logic signed [COORD_BITS-1:0] bx_reg, bx_next;
    logic signed [COORD_BITS-1:0] by_reg, by_next;
    logic signed [COORD_BITS-1:0] cx_reg, cx_next;
    logic signed [COORD_BITS-1:0] cy_reg, cy_next;
    logic signed [PRW-1:0]        prod1_reg, prod1_next;
    logic signed [PRW-1:0]        prod2_reg, prod2_next;
    logic [IDX_W-1:0]             cur_reg, cur_next;
    logic [IDX_W-1:0]             pivot_idx_reg, pivot_idx_next;
    logic                         pivot_valid_reg, pivot_valid_next;
    logic [IDX_W-1:0]             first_idx_reg, first_idx_next;
    logic                         first_valid_reg, first_valid_next;
    logic [CNT_W-1:0]             i_reg, i_next;
    logic [HB_CW-1:0]             rounds_reg, rounds_next;
    logic [HB_CW-1:0]             nres_reg, nres_next;
    logic [HB_CW-1:0]             k_reg, k_next;
    logic                         limit_hit_reg, limit_hit_next;
    logic                         out_valid_reg, out_valid_next;
    logic [HULL_IDX_BITS-1:0]     hull_index_reg, hull_index_next;
    logic                         last_vertex_reg, last_vertex_next;
    logic                         unfinished_reg, unfinished_next;

    ctrl_t                         ctrl;
    logic                          in_accept;
    logic                          store_ok;
    logic                          wait_ok;
    logic                          cond_true;
    logic                          emit;
    logic [IDX_W-1:0]              cur_init;
    logic                          single;
    logic                          limit;
    logic [HB_CW-1:0]              rounds_inc;
    logic [HB_CW-1:0]              n_plus2;
    logic [HB_CW-1:0]              k_inc;
    logic signed [COORD_BITS-1:0]  rd_x;
    logic signed [COORD_BITS-1:0]  rd_y;
    logic signed [DW-1:0]          mul_a;
    logic signed [DW-1:0]          mul_b;
    logic signed [PRW-1:0]         prod;
    logic [IDX_W+HULL_IDX_BITS-1:0] hull_wide;

    assign ctrl      = gwch_ucode(upc_reg);
    assign in_ready  = (upc_reg == UA_IDLE);
    assign in_accept = in_valid && in_ready;
    assign store_ok  = (count_reg < CNT_W'(MAX_POINTS));
    assign cur_init  = (pivot_valid_reg && (pivot_idx_reg == '0)) ? IDX_W'(1) : '0;
    assign single    = (n_reg == CNT_W'(1));
    assign rounds_inc = rounds_reg + HB_CW'(1);
    assign n_plus2   = HB_CW'(n_reg) + HB_CW'(2);
    assign limit     = (rounds_inc == n_plus2);
    assign k_inc     = k_reg + HB_CW'(1);
    assign rd_x      = $signed(pt_rdata_reg[2*COORD_BITS-1:COORD_BITS]);
    assign rd_y      = $signed(pt_rdata_reg[COORD_BITS-1:0]);
    assign hull_wide = {{HULL_IDX_BITS{1'b0}}, hb_rdata_reg};

    assign pt_we    = in_accept && store_ok;
    assign pt_waddr = count_reg[IDX_W-1:0];
    assign pt_raddr = (ctrl.op == OP_RINIT) ? cur_init : i_reg[IDX_W-1:0];
    assign hb_we    = (ctrl.op == OP_ADVANCE);

    // Shared multiplier: the two products of the cross product are formed in turn.
    always_comb
    begin
        if (ctrl.op == OP_MUL1)
        begin
            mul_a = DW'(bx_reg) - DW'(px_reg);
            mul_b = DW'(cy_reg) - DW'(py_reg);
        end
        else
        begin
            mul_a = DW'(cx_reg) - DW'(px_reg);
            mul_b = DW'(by_reg) - DW'(py_reg);
        end
        prod = mul_a * mul_b;
    end

    always_comb
    begin
        unique case (ctrl.wt)
            W_NONE:  wait_ok = 1'b1;
            W_START: wait_ok = in_valid && last_point;
            W_OUT:   wait_ok = !out_valid_reg || out_ready;
            default: wait_ok = 1'b0;
        endcase

        unique case (ctrl.cond)
            C_NEVER:     cond_true = 1'b0;
            C_ALWAYS:    cond_true = 1'b1;
            C_I_END:     cond_true = (i_reg >= n_reg);
            C_I_PIVOT:   cond_true = pivot_valid_reg && (i_reg[IDX_W-1:0] == pivot_idx_reg);
            C_CLOSED:    cond_true = first_valid_reg && (cur_reg == first_idx_reg);
            C_NOT_LIMIT: cond_true = !limit && !single;
            C_MORE:      cond_true = (k_inc != nres_reg);
            default:     cond_true = 1'b0;
        endcase

        if (!wait_ok)
            upc_next = upc_reg;
        else if (cond_true)
            upc_next = ctrl.target;
        else
            upc_next = upc_reg + UPC_W'(1);

        emit = (ctrl.op == OP_EMIT) && wait_ok;
    end

    always_comb
    begin
        count_next       = count_reg;
        n_next           = n_reg;
        min_x_next       = min_x_reg;
        min_y_next       = min_y_reg;
        px_next          = px_reg;
        py_next          = py_reg;
        bx_next          = bx_reg;
        by_next          = by_reg;
        cx_next          = cx_reg;
        cy_next          = cy_reg;
        prod1_next       = prod1_reg;
        prod2_next       = prod2_reg;
        cur_next         = cur_reg;
        pivot_idx_next   = pivot_idx_reg;
        pivot_valid_next = pivot_valid_reg;
        first_idx_next   = first_idx_reg;
        first_valid_next = first_valid_reg;
        i_next           = i_reg;
        rounds_next      = rounds_reg;
        nres_next        = nres_reg;
        k_next           = k_reg;
        limit_hit_next   = limit_hit_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        hull_index_next  = hull_index_reg;
        last_vertex_next = last_vertex_reg;
        unfinished_next  = unfinished_reg;

        if (in_accept)
        begin
            if (store_ok)
            begin
                count_next = count_reg + CNT_W'(1);
                if ((count_reg == '0) || (x_coord < min_x_reg))
                    min_x_next = x_coord;
                if ((count_reg == '0) || (y_coord < min_y_reg))
                    min_y_next = y_coord;
            end
            // The last beat starts a run from the virtual pivot below and left of all points.
            if (last_point)
            begin
                n_next           = count_next;
                count_next       = '0;
                px_next          = PW'(min_x_next) - PW'(1);
                py_next          = PW'(min_y_next) - PW'(1);
                pivot_valid_next = 1'b0;
                first_valid_next = 1'b0;
                rounds_next      = '0;
                nres_next        = '0;
                k_next           = '0;
                limit_hit_next   = 1'b0;
            end
        end

        unique case (ctrl.op)
            OP_RINIT:
            begin
                cur_next = cur_init;
                i_next   = CNT_W'(1);
            end
            OP_LDB:
            begin
                bx_next = rd_x;
                by_next = rd_y;
            end
            OP_LDC:
            begin
                cx_next = rd_x;
                cy_next = rd_y;
            end
            OP_MUL1:
                prod1_next = prod;
            OP_MUL2:
                prod2_next = prod;
            OP_CMP:
            begin
                // A collinear tie also moves the candidate, so the later index wins.
                if (!(prod1_reg > prod2_reg))
                begin
                    cur_next = i_reg[IDX_W-1:0];
                    bx_next  = cx_reg;
                    by_next  = cy_reg;
                end
            end
            OP_INC_I:
                i_next = i_reg + CNT_W'(1);
            OP_ADVANCE:
            begin
                pivot_idx_next   = cur_reg;
                pivot_valid_next = 1'b1;
                px_next          = PW'(bx_reg);
                py_next          = PW'(by_reg);
                nres_next        = nres_reg + HB_CW'(1);
                rounds_next      = rounds_inc;
                limit_hit_next   = limit && !single;
                if (!first_valid_reg)
                begin
                    first_idx_next   = cur_reg;
                    first_valid_next = 1'b1;
                end
            end
            OP_EMIT:
            begin
                if (emit)
                begin
                    out_valid_next   = 1'b1;
                    hull_index_next  = hull_wide[HULL_IDX_BITS-1:0];
                    last_vertex_next = (k_inc == nres_reg);
                    unfinished_next  = limit_hit_reg;
                    k_next           = k_inc;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (pt_we)
            pt_mem[pt_waddr] <= {x_coord, y_coord};
        pt_rdata_reg <= pt_mem[pt_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (hb_we)
            hb_mem[nres_reg[HB_AW-1:0]] <= cur_reg;
        hb_rdata_reg <= hb_mem[k_reg[HB_AW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg         <= UA_IDLE;
            count_reg       <= '0;
            n_reg           <= '0;
            cur_reg         <= '0;
            pivot_idx_reg   <= '0;
            pivot_valid_reg <= 1'b0;
            first_idx_reg   <= '0;
            first_valid_reg <= 1'b0;
            i_reg           <= '0;
            rounds_reg      <= '0;
            nres_reg        <= '0;
            k_reg           <= '0;
            limit_hit_reg   <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            upc_reg         <= upc_next;
            count_reg       <= count_next;
            n_reg           <= n_next;
            cur_reg         <= cur_next;
            pivot_idx_reg   <= pivot_idx_next;
            pivot_valid_reg <= pivot_valid_next;
            first_idx_reg   <= first_idx_next;
            first_valid_reg <= first_valid_next;
            i_reg           <= i_next;
            rounds_reg      <= rounds_next;
            nres_reg        <= nres_next;
            k_reg           <= k_next;
            limit_hit_reg   <= limit_hit_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        min_x_reg       <= min_x_next;
        min_y_reg       <= min_y_next;
        px_reg          <= px_next;
        py_reg          <= py_next;
        bx_reg          <= bx_next;
        by_reg          <= by_next;
        cx_reg          <= cx_next;
        cy_reg          <= cy_next;
        prod1_reg       <= prod1_next;
        prod2_reg       <= prod2_next;
        hull_index_reg  <= hull_index_next;
        last_vertex_reg <= last_vertex_next;
        unfinished_reg  <= unfinished_next;
    end

    assign out_valid   = out_valid_reg;
    assign hull_index  = hull_index_reg;
    assign last_vertex = last_vertex_reg;
    assign unfinished  = unfinished_reg;

    // A point loaded for comparison is always in the set and never the pivot.
    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (upc_reg == UA_LDC) |-> ((i_reg < n_reg) &&
            !(pivot_valid_reg && (i_reg[IDX_W-1:0] == pivot_idx_reg))))
        else $error("scan read outside the set or at the pivot");

    a_cand_not_pivot: assert property (@(posedge clk) disable iff (!rst_n)
        (upc_reg == UA_CMP) |-> !(pivot_valid_reg && (cur_reg == pivot_idx_reg)))
        else $error("candidate equals pivot");

    a_hull_bound: assert property (@(posedge clk) disable iff (!rst_n)
        nres_reg <= n_plus2)
        else $error("hull buffer overrun");

    a_emit_shows: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> (out_valid_reg && (k_reg != '0)))
        else $error("emitted beat not presented");

endmodule
